// ===== hw/rtl/sut_pkg.sv =====
// Shared types and constants for the sorted unique key table.
package sut_pkg;

  // Field widths of the request and result channels
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 4;

  // Default number of table slots
  localparam int unsigned CAPACITY_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_EMIT
  } state_e;

endpackage

// ===== hw/rtl/sut_if.sv =====
// Request and result channel interfaces of the sorted unique key table.
interface sut_req_if;
  logic                                valid;
  logic                                ready;
  logic [sut_pkg::CMD_W-1:0]           command;
  logic signed [sut_pkg::KEY_W-1:0]    key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface sut_res_if;
  logic                                valid;
  logic                                ready;
  logic [sut_pkg::STATUS_W-1:0]        status;
  logic signed [sut_pkg::KEY_W-1:0]    value;
  logic [sut_pkg::CNT_W-1:0]           count;
  logic                                last;

  modport source (output valid, output status, output value, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input value, input count, input last,
                  output ready);
endinterface

// ===== hw/rtl/sorted_unique_table.sv =====
// Insert and delete scan the entries in order, a read state and a check state per entry, then
// shift entries one at a time, a read and a write state per entry, then end with the result.
// A dump reads each entry, then outputs it; full, empty and empty-dump results go to S_EMIT.
// One request at a time: ready is high only in S_IDLE, so a new request waits until the result
// of the last one is loaded; output stalls add to this. All reads use the store's single read port.
// Reset clears the fill count and control state; key storage is not cleared.
module sorted_unique_table #(
  parameter int unsigned CAPACITY = sut_pkg::CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sut_req_if.sink  req_i,
  sut_res_if.source res_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  sut_pkg::state_e state_q, state_d;
  logic [FW-1:0]   idx_q, idx_d;
  logic [FW-1:0]   pos_q, pos_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [sut_pkg::CMD_W-1:0]        cmd_q, cmd_d;
  logic signed [sut_pkg::KEY_W-1:0] key_q, key_d;
  logic [sut_pkg::STATUS_W-1:0]     rst_q, rst_d;   // result status
  logic signed [sut_pkg::KEY_W-1:0] rval_q, rval_d; // result value

  // Output register
  logic                             ovalid_q;
  logic [sut_pkg::STATUS_W-1:0]     ostatus_q;
  logic signed [sut_pkg::KEY_W-1:0] ovalue_q;
  logic [sut_pkg::CNT_W-1:0]        ocount_q;
  logic                             olast_q;

  // Store port
  logic                             mem_we, mem_re;
  logic [AW-1:0]                    mem_waddr, mem_raddr;
  logic signed [sut_pkg::KEY_W-1:0] mem_wdata, mem_rdata;

  logic                             out_free, out_load, req_take;
  logic [sut_pkg::STATUS_W-1:0]     load_status;
  logic signed [sut_pkg::KEY_W-1:0] load_value;
  logic                             load_last;
  logic [FW-1:0]                    idx_inc, idx_dec;
  logic                             idx_at_fill, next_is_last, is_insert;

  sut_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_free     = !ovalid_q || res_o.ready;
  assign req_take     = req_i.valid && req_i.ready;
  assign idx_inc      = idx_q + FW'(1);
  assign idx_dec      = idx_q - FW'(1);
  assign idx_at_fill  = (idx_q == fill_q);
  assign next_is_last = (idx_inc == fill_q);
  assign is_insert    = (cmd_q == sut_pkg::CMD_INSERT);

  // Next state and working registers
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    fill_d  = fill_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    rst_d   = rst_q;
    rval_d  = rval_q;
    unique case (state_q)
      sut_pkg::S_IDLE: begin
        if (req_take) begin
          cmd_d  = req_i.command;
          key_d  = req_i.key;
          rval_d = req_i.key;
          idx_d  = '0;
          pos_d  = fill_q;
          case (req_i.command)
            sut_pkg::CMD_INSERT: begin
              if (fill_q == FW'(CAPACITY)) begin
                rst_d   = sut_pkg::ST_FULL;
                state_d = sut_pkg::S_EMIT;
              end else begin
                state_d = sut_pkg::S_SCAN_RD;
              end
            end
            sut_pkg::CMD_DELETE: begin
              if (fill_q == '0) begin
                rst_d   = sut_pkg::ST_EMPTY;
                state_d = sut_pkg::S_EMIT;
              end else begin
                state_d = sut_pkg::S_SCAN_RD;
              end
            end
            sut_pkg::CMD_DUMP: begin
              if (fill_q == '0) begin
                rst_d   = sut_pkg::ST_EMPTY;
                rval_d  = '0;
                state_d = sut_pkg::S_EMIT;
              end else begin
                state_d = sut_pkg::S_DUMP_RD;
              end
            end
            default: state_d = sut_pkg::S_IDLE; // unused code: dropped
          endcase
        end
      end
      sut_pkg::S_SCAN_RD: begin
        if (idx_at_fill) begin
          if (is_insert) begin
            state_d = sut_pkg::S_UP_RD;   // append at the end
          end else begin
            rst_d   = sut_pkg::ST_MISSING;
            state_d = sut_pkg::S_EMIT;
          end
        end else begin
          state_d = sut_pkg::S_SCAN_CHK;
        end
      end
      sut_pkg::S_SCAN_CHK: begin
        if (mem_rdata == key_q) begin
          if (is_insert) begin
            rst_d   = sut_pkg::ST_DUP;
            state_d = sut_pkg::S_EMIT;
          end else begin
            state_d = sut_pkg::S_DN_RD;
          end
        end else if (key_q < mem_rdata) begin
          // sorted: nothing further can match
          if (is_insert) begin
            pos_d   = idx_q;
            idx_d   = fill_q;
            state_d = sut_pkg::S_UP_RD;
          end else begin
            rst_d   = sut_pkg::ST_MISSING;
            state_d = sut_pkg::S_EMIT;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = sut_pkg::S_SCAN_RD;
        end
      end
      sut_pkg::S_UP_RD: begin
        if (idx_q == pos_q) begin
          fill_d  = fill_q + FW'(1);
          rst_d   = sut_pkg::ST_OK;
          state_d = sut_pkg::S_EMIT;
        end else begin
          state_d = sut_pkg::S_UP_WR;
        end
      end
      sut_pkg::S_UP_WR: begin
        idx_d   = idx_dec;
        state_d = sut_pkg::S_UP_RD;
      end
      sut_pkg::S_DN_RD: begin
        if (next_is_last) begin
          fill_d  = fill_q - FW'(1);
          rst_d   = sut_pkg::ST_OK;
          state_d = sut_pkg::S_EMIT;
        end else begin
          state_d = sut_pkg::S_DN_WR;
        end
      end
      sut_pkg::S_DN_WR: begin
        idx_d   = idx_inc;
        state_d = sut_pkg::S_DN_RD;
      end
      sut_pkg::S_DUMP_RD: begin
        state_d = sut_pkg::S_DUMP_OUT;
      end
      sut_pkg::S_DUMP_OUT: begin
        if (out_free) begin
          if (next_is_last) begin
            state_d = sut_pkg::S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = sut_pkg::S_DUMP_RD;
          end
        end
      end
      sut_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = sut_pkg::S_IDLE;
        end
      end
      default: state_d = sut_pkg::S_IDLE;
    endcase
  end

  // Store accesses, request ready and result load
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx_q[AW-1:0];
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    load_status = rst_q;
    load_value  = rval_q;
    load_last   = 1'b1;
    unique case (state_q)
      sut_pkg::S_IDLE: req_i.ready = 1'b1;
      sut_pkg::S_SCAN_RD: mem_re = !idx_at_fill;
      sut_pkg::S_UP_RD: begin
        if (idx_q == pos_q) begin
          mem_we    = 1'b1;
          mem_wdata = key_q;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end
      end
      sut_pkg::S_UP_WR: mem_we = 1'b1;
      sut_pkg::S_DN_RD: begin
        mem_re    = !next_is_last;
        mem_raddr = idx_inc[AW-1:0];
      end
      sut_pkg::S_DN_WR: mem_we = 1'b1;
      sut_pkg::S_DUMP_RD: mem_re = 1'b1;
      sut_pkg::S_DUMP_OUT: begin
        out_load    = out_free;
        load_status = sut_pkg::ST_OK;
        load_value  = mem_rdata;
        load_last   = next_is_last;
      end
      sut_pkg::S_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sut_pkg::S_IDLE;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (res_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    rst_q  <= rst_d;
    rval_q <= rval_d;
    if (out_load) begin
      ostatus_q <= load_status;
      ovalue_q  <= load_value;
      ocount_q  <= sut_pkg::CNT_W'(fill_q);
      olast_q   <= load_last;
    end
  end

  assign res_o.valid  = ovalid_q;
  assign res_o.status = ostatus_q;
  assign res_o.value  = ovalue_q;
  assign res_o.count  = ocount_q;
  assign res_o.last   = olast_q;

endmodule

// ===== hw/rtl/sut_store.sv =====
// Key storage: one write port, one read port, registered read data.
module sut_store #(
  parameter int unsigned CAPACITY = sut_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = 1
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [sut_pkg::KEY_W-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [sut_pkg::KEY_W-1:0] rdata_o
);

  logic signed [sut_pkg::KEY_W-1:0] mem_q [CAPACITY];
  logic signed [sut_pkg::KEY_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
